FILE: sv/fia_pkg.sv
// ----------------------------------------------------------------------------
// fia_pkg
// shared types and constants for the fifo index allocator
// ----------------------------------------------------------------------------
package fia_pkg;

  localparam int IDX_W            = 11;
  localparam int DEFAULT_CAPACITY = 1024;
  localparam int RESET_COUNT      = 1024;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_t;

  // one entry of the link store: in-use mark and successor index
  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] link;
  } word_t;

endpackage

FILE: sv/fifo_index_allocator.sv
// ----------------------------------------------------------------------------
// fifo_index_allocator
// hands out indices 1..count from a linked free list, reuse in free order
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. in_req_type selects
// allocate or free; in_free_index is the index returned on a free. Each
// request gives exactly one result, shown for one cycle with out_valid high:
// out_granted_index (0 when the pool is empty or on a free), out_free_ok and
// out_used_count. The receiver cannot stall; results are never held.
// All list state sits in one single-port memory of CAPACITY words, each with
// an in-use mark and a next pointer, with a registered read.
// An allocate's result is registered from the EXEC state; a free's likewise,
// or from the LINK state when the freed index is linked behind a non-empty
// tail, since that needs a second write to the same memory port. A new
// request may be taken in the cycle its predecessor's result is shown.
// Reset and every write on the cfg channel load index_count (saturated to
// CAPACITY) and start a sweep over all CAPACITY words that rebuilds the chain
// 1..count and clears all in-use marks; busy stays high during the sweep.
// cfg_ready is high only when idle, with no request offered and no result out.
// ----------------------------------------------------------------------------
module fifo_index_allocator #(
  parameter int CAPACITY = fia_pkg::DEFAULT_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_req_type,
  input  logic [fia_pkg::IDX_W-1:0] in_free_index,
  output logic                     out_valid,
  output logic [fia_pkg::IDX_W-1:0] out_granted_index,
  output logic                     out_free_ok,
  output logic [fia_pkg::IDX_W-1:0] out_used_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [fia_pkg::IDX_W-1:0] cfg_data
);
  import fia_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int RESET_SAT = (RESET_COUNT > CAPACITY) ? CAPACITY : RESET_COUNT;

  word_t link_mem [CAPACITY];
  word_t rd_word_r;

  state_t state_r, state_nxt;

  logic [AW-1:0]    init_r, init_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] total_r, total_nxt;
  logic             type_r, type_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_grant_r, out_grant_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [IDX_W-1:0] out_used_r, out_used_nxt;

  logic             cfg_wr;
  logic             accept;
  logic             free_ok;
  logic [IDX_W-1:0] cfg_sat;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  word_t            mem_wdata;
  logic [AW-1:0]    mem_raddr;

  // a count write never meets a request or a result in the same cycle
  assign cfg_ready = (state_r == S_IDLE) && !start && !out_valid_r;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  assign cfg_sat = (CW'(cfg_data) > CW'(CAPACITY)) ? IDX_W'(CAPACITY) : cfg_data;

  // a free is good only for an in-range index whose mark is set
  assign free_ok = (idx_r != '0) && (idx_r <= count_r) && rd_word_r.used;

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_grant_r;
  assign out_free_ok       = out_ok_r;
  assign out_used_count    = out_used_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (init_r == AW'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (type_r == REQ_FREE && free_ok && tail_r != '0) state_nxt = S_LINK;
        else state_nxt = S_IDLE;
      end
      S_LINK: state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
    if (cfg_wr) state_nxt = S_INIT;
  end

  // datapath and memory control
  always_comb begin
    init_nxt      = init_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    total_nxt     = total_r;
    type_nxt      = type_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_grant_nxt = out_grant_r;
    out_ok_nxt    = out_ok_r;
    out_used_nxt  = out_used_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    unique case (state_r)
      S_INIT: begin
        mem_we         = 1'b1;
        mem_waddr      = init_r;
        mem_wdata.used = 1'b0;
        mem_wdata.link = ((CW'(init_r) + CW'(1)) < CW'(count_r)) ?
                         IDX_W'(CW'(init_r) + CW'(2)) : '0;
        init_nxt       = init_r + AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          type_nxt  = in_req_type;
          idx_nxt   = in_free_index;
          mem_raddr = (in_req_type == REQ_FREE) ? AW'(in_free_index - IDX_W'(1)) :
                                                  AW'(head_r - IDX_W'(1));
        end
      end
      S_EXEC: begin
        out_grant_nxt = '0;
        out_ok_nxt    = 1'b0;
        out_used_nxt  = total_r;
        if (type_r == REQ_ALLOC) begin
          out_valid_nxt = 1'b1;
          if (head_r != '0) begin
            mem_we         = 1'b1;
            mem_waddr      = AW'(head_r - IDX_W'(1));
            mem_wdata.used = 1'b1;
            mem_wdata.link = '0;
            head_nxt       = rd_word_r.link;
            if (rd_word_r.link == '0) tail_nxt = '0;
            total_nxt      = total_r + IDX_W'(1);
            out_grant_nxt  = head_r;
            out_used_nxt   = total_r + IDX_W'(1);
          end
        end else begin
          if (free_ok) begin
            mem_we     = 1'b1;
            mem_waddr  = AW'(idx_r - IDX_W'(1));
            mem_wdata  = '0;
            total_nxt  = (total_r != '0) ? total_r - IDX_W'(1) : total_r;
            out_used_nxt = (total_r != '0) ? total_r - IDX_W'(1) : total_r;
            out_ok_nxt = 1'b1;
            // empty list: freed index becomes the whole list
            if (tail_r == '0) begin
              head_nxt      = idx_r;
              tail_nxt      = idx_r;
              out_valid_nxt = 1'b1;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_LINK: begin
        mem_we         = 1'b1;
        mem_waddr      = AW'(tail_r - IDX_W'(1));
        mem_wdata.used = 1'b0;
        mem_wdata.link = idx_r;
        tail_nxt       = idx_r;
        out_valid_nxt  = 1'b1;
      end
      default: begin
        init_nxt = '0;
      end
    endcase

    if (cfg_wr) begin
      init_nxt      = '0;
      count_nxt     = cfg_sat;
      head_nxt      = (cfg_sat != '0) ? IDX_W'(1) : '0;
      tail_nxt      = cfg_sat;
      total_nxt     = '0;
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      count_r     <= IDX_W'(RESET_SAT);
      head_r      <= (RESET_SAT != 0) ? IDX_W'(1) : '0;
      tail_r      <= IDX_W'(RESET_SAT);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r      <= type_nxt;
    idx_r       <= idx_nxt;
    out_grant_r <= out_grant_nxt;
    out_ok_r    <= out_ok_nxt;
    out_used_r  <= out_used_nxt;
  end

  // single-port link store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    rd_word_r <= link_mem[mem_raddr];
  end

endmodule

FILE: sv/fia_checker.sv
// ----------------------------------------------------------------------------
// fia_checker
// port-level checks for the fifo index allocator
// ----------------------------------------------------------------------------
module fia_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [fia_pkg::IDX_W-1:0] out_granted_index,
  input logic                      out_free_ok,
  input logic [fia_pkg::IDX_W-1:0] out_used_count,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);
  import fia_pkg::*;

  // a taken request shows busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // a count write starts the rebuild sweep
  a_cfg_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy && !out_valid)
    else $error("count write did not start the sweep");

  // a result never grants and confirms a free at once
  a_grant_or_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted_index != '0 && out_free_ok))
    else $error("grant and free_ok both set");

  // a granted index is counted as in use
  a_grant_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted_index != '0 |-> out_used_count != '0)
    else $error("grant with zero used count");

  // results only follow work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

endmodule

bind fifo_index_allocator fia_checker u_fia_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_granted_index (out_granted_index),
  .out_free_ok       (out_free_ok),
  .out_used_count    (out_used_count),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready)
);
